[rtl/core/rolling_window_ohlc_assert.svh]
// Assertion macros shared by the rolling window OHLC RTL.
`ifndef ROLLING_WINDOW_OHLC_ASSERT_SVH
`define ROLLING_WINDOW_OHLC_ASSERT_SVH

// Condition must hold on every clock edge outside reset.
`define RWO_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Implication in the same cycle, outside reset.
`define RWO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle, outside reset.
`define RWO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/rwo_pkg.sv]
// Shared constants and types for the rolling window OHLC block.
`timescale 1ns / 1ps
package rwo_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int PRICE_WIDTH_DEF = 32;
    localparam int TAG_WIDTH       = 32;
    localparam int LEN_WIDTH       = 7;
    localparam logic [LEN_WIDTH-1:0] LEN_RESET = 7'd25;

    // Per-cell control from the top level.
    typedef struct packed {
        logic shift;    // load bar from left neighbor
        logic in_win;   // cell lies inside the current window
        logic oldest;   // cell holds the oldest bar of the window
    } t_cell_ctl;

endpackage

[rtl/core/rwo_cell.sv]
// One window cell: holds a bar and folds it into the passing accumulator.
`timescale 1ns / 1ps
module rwo_cell
    import rwo_pkg::*;
#(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [TAG_WIDTH-1:0]   i_tag,
    input  logic [PRICE_WIDTH-1:0] i_high,
    input  logic [PRICE_WIDTH-1:0] i_low,
    input  logic [PRICE_WIDTH-1:0] i_close,
    output logic [TAG_WIDTH-1:0]   o_tag,
    output logic [PRICE_WIDTH-1:0] o_high,
    output logic [PRICE_WIDTH-1:0] o_low,
    output logic [PRICE_WIDTH-1:0] o_close,
    input  logic [TAG_WIDTH-1:0]   i_acc_tag,
    input  logic [PRICE_WIDTH-1:0] i_acc_close,
    input  logic [PRICE_WIDTH-1:0] i_acc_hi,
    input  logic [PRICE_WIDTH-1:0] i_acc_lo,
    output logic [TAG_WIDTH-1:0]   o_acc_tag,
    output logic [PRICE_WIDTH-1:0] o_acc_close,
    output logic [PRICE_WIDTH-1:0] o_acc_hi,
    output logic [PRICE_WIDTH-1:0] o_acc_lo
);

    logic [TAG_WIDTH-1:0]   r_tag;
    logic [PRICE_WIDTH-1:0] r_high;
    logic [PRICE_WIDTH-1:0] r_low;
    logic [PRICE_WIDTH-1:0] r_close;
    logic [TAG_WIDTH-1:0]   r_acc_tag;
    logic [PRICE_WIDTH-1:0] r_acc_close;
    logic [PRICE_WIDTH-1:0] r_acc_hi;
    logic [PRICE_WIDTH-1:0] r_acc_lo;

    // bar storage, shifts one place on each accepted bar
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_tag   <= i_tag;
            r_high  <= i_high;
            r_low   <= i_low;
            r_close <= i_close;
        end
    end

    // accumulator stage, moves one cell per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.in_win) begin
            r_acc_hi <= ($signed(r_high) > $signed(i_acc_hi)) ? r_high : i_acc_hi;
            r_acc_lo <= ($signed(r_low) < $signed(i_acc_lo)) ? r_low : i_acc_lo;
        end else begin
            r_acc_hi <= i_acc_hi;
            r_acc_lo <= i_acc_lo;
        end
        if (i_ctl.in_win && i_ctl.oldest) begin
            r_acc_tag   <= r_tag;
            r_acc_close <= r_close;
        end else begin
            r_acc_tag   <= i_acc_tag;
            r_acc_close <= i_acc_close;
        end
    end

    assign o_tag       = r_tag;
    assign o_high      = r_high;
    assign o_low       = r_low;
    assign o_close     = r_close;
    assign o_acc_tag   = r_acc_tag;
    assign o_acc_close = r_acc_close;
    assign o_acc_hi    = r_acc_hi;
    assign o_acc_lo    = r_acc_lo;

endmodule

[rtl/core/rolling_window_ohlc.sv]
// Flow: an accepted bar shifts into cell 0, and the result is loaded into the output register
//   at the end of the sweep. The accumulator ripples one cell a cycle down the row of
//   WINDOW_MAX cells, and the control returns to idle before it takes the next bar.
// A result still waiting when the next sweep ends holds that sweep, and s_axis_tready.
// Reset (sync, active low) sets window_length to 25, empties the fill count and the
//   output register; cell contents stay undefined and are never used unfilled.
`timescale 1ns / 1ps
`include "rolling_window_ohlc_assert.svh"
module rolling_window_ohlc
    import rwo_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config: window_length
    input  logic                 i_cfg_wr_en,
    input  logic [LEN_WIDTH-1:0] i_cfg_wr_data,
    // bars in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, low bit up: bar_tag, open_price, high_price, low_price, close_price, zero pad
    input  logic [((TAG_WIDTH + 4 * PRICE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // results out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, low bit up: window_tag, window_open, window_close, window_high,
    // window_low, zero pad
    output logic [((TAG_WIDTH + 4 * PRICE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int PAYLOAD_W = TAG_WIDTH + 4 * PRICE_WIDTH;
    localparam int DATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int CW        = $clog2(WINDOW_MAX + 1);
    localparam int EW        = (CW > LEN_WIDTH) ? CW : LEN_WIDTH;
    localparam int P0        = TAG_WIDTH;

    // control states
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    // extreme seeds for the accumulator entering cell 0
    localparam logic [PRICE_WIDTH-1:0] PRICE_MIN = {1'b1, {(PRICE_WIDTH - 1){1'b0}}};
    localparam logic [PRICE_WIDTH-1:0] PRICE_MAX = {1'b0, {(PRICE_WIDTH - 1){1'b1}}};

    logic                   r_state, n_state;
    logic [LEN_WIDTH-1:0]   r_len;
    logic [CW-1:0]          r_fill;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [PRICE_WIDTH-1:0] r_open;
    logic                   r_out_valid;
    logic [PAYLOAD_W-1:0]   r_out;

    logic                   w_in_fire;
    logic                   w_out_fire;
    logic                   w_sweep_done;
    logic                   w_emit;
    logic                   w_load;
    logic [EW-1:0]          w_eff;

    // per-cell links: index i feeds cell i, index i+1 is cell i's output
    logic [TAG_WIDTH-1:0]   w_tag   [WINDOW_MAX+1];
    logic [PRICE_WIDTH-1:0] w_high  [WINDOW_MAX+1];
    logic [PRICE_WIDTH-1:0] w_low   [WINDOW_MAX+1];
    logic [PRICE_WIDTH-1:0] w_close [WINDOW_MAX+1];
    logic [TAG_WIDTH-1:0]   w_acc_tag   [WINDOW_MAX+1];
    logic [PRICE_WIDTH-1:0] w_acc_close [WINDOW_MAX+1];
    logic [PRICE_WIDTH-1:0] w_acc_hi    [WINDOW_MAX+1];
    logic [PRICE_WIDTH-1:0] w_acc_lo    [WINDOW_MAX+1];

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    // new bar enters only between sweeps
    assign s_axis_tready = (r_state == ST_IDLE);

    // effective window length: zero acts as one, clipped at WINDOW_MAX
    always_comb begin
        if (r_len == '0) begin
            w_eff = EW'(1);
        end else if (EW'(r_len) > EW'(WINDOW_MAX)) begin
            w_eff = EW'(WINDOW_MAX);
        end else begin
            w_eff = EW'(r_len);
        end
    end

    assign w_sweep_done = (r_state == ST_SWEEP) && (r_cnt == CW'(WINDOW_MAX));
    assign w_emit       = (EW'(r_fill) >= w_eff);
    // result goes out when the output register is free or drains this cycle
    assign w_load       = w_sweep_done && w_emit && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_SWEEP;
                    n_cnt   = '0;
                end
            end
            ST_SWEEP: begin
                if (r_cnt != CW'(WINDOW_MAX)) begin
                    n_cnt = r_cnt + CW'(1);
                end else if (!w_emit || w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_len       <= LEN_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (w_in_fire && (r_fill != CW'(WINDOW_MAX))) begin
                r_fill <= r_fill + CW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_open <= s_axis_tdata[P0 +: PRICE_WIDTH];
        end
        if (w_load) begin
            r_out <= {w_acc_lo[WINDOW_MAX], w_acc_hi[WINDOW_MAX], w_acc_close[WINDOW_MAX],
                      r_open, w_acc_tag[WINDOW_MAX]};
        end
    end

    // head of the row: new bar and accumulator seed
    assign w_tag[0]       = s_axis_tdata[0 +: TAG_WIDTH];
    assign w_high[0]      = s_axis_tdata[P0 + PRICE_WIDTH +: PRICE_WIDTH];
    assign w_low[0]       = s_axis_tdata[P0 + 2 * PRICE_WIDTH +: PRICE_WIDTH];
    assign w_close[0]     = s_axis_tdata[P0 + 3 * PRICE_WIDTH +: PRICE_WIDTH];
    assign w_acc_tag[0]   = '0;
    assign w_acc_close[0] = '0;
    assign w_acc_hi[0]    = PRICE_MIN;
    assign w_acc_lo[0]    = PRICE_MAX;

    // row of window cells; cell 0 holds the newest bar
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.shift  = w_in_fire;
        assign w_ctl.in_win = (EW'(g) < w_eff);
        assign w_ctl.oldest = (EW'(g) == (w_eff - EW'(1)));

        rwo_cell #(
            .PRICE_WIDTH (PRICE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_tag       (w_tag[g]),
            .i_high      (w_high[g]),
            .i_low       (w_low[g]),
            .i_close     (w_close[g]),
            .o_tag       (w_tag[g+1]),
            .o_high      (w_high[g+1]),
            .o_low       (w_low[g+1]),
            .o_close     (w_close[g+1]),
            .i_acc_tag   (w_acc_tag[g]),
            .i_acc_close (w_acc_close[g]),
            .i_acc_hi    (w_acc_hi[g]),
            .i_acc_lo    (w_acc_lo[g]),
            .o_acc_tag   (w_acc_tag[g+1]),
            .o_acc_close (w_acc_close[g+1]),
            .o_acc_hi    (w_acc_hi[g+1]),
            .o_acc_lo    (w_acc_lo[g+1])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    // zero pad above the payload
    assign m_axis_tdata  = DATA_W'(r_out);

    // fill count saturates at the row length
    `RWO_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(WINDOW_MAX))
    // sweep counter never passes the row length
    `RWO_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(WINDOW_MAX))
    // an accepted bar starts a fresh sweep
    `RWO_ASSERT_NEXT(a_sweep_start, i_clk, i_rst_n, w_in_fire,
        (r_state == ST_SWEEP) && (r_cnt == '0))
    // a result appears only at the end of a full sweep
    `RWO_ASSERT_IMPL(a_out_at_end, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_cnt) == CW'(WINDOW_MAX))

endmodule

[tb/sv/rolling_window_ohlc_tb.sv]
// Self-checking testbench for the rolling window OHLC block: bars in, window summaries out.
`timescale 1ns / 1ps
module rolling_window_ohlc_tb;
    import rwo_pkg::*;

    localparam int PW             = PRICE_WIDTH_DEF;
    localparam int DEPTH          = WINDOW_MAX_DEF;
    localparam int BUS_W          = ((TAG_WIDTH + 4 * PW + 7) / 8) * 8;
    // A bar that makes no result may still be in flight when the last result lands, so
    // settle past the end of its sweep.
    localparam int DRAIN_CYCLES   = DEPTH + 16;
    // Slowest correct run is roughly 1825 bars, each with its sweep, idle gaps and stalls;
    // leave a wide margin.
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_PHASES  = 12;
    localparam int BARS_PER_PHASE = 150;

    localparam logic signed [PW-1:0] PRICE_MIN = {1'b1, {(PW - 1){1'b0}}};
    localparam logic signed [PW-1:0] PRICE_MAX = {1'b0, {(PW - 1){1'b1}}};

    typedef logic signed [PW-1:0] t_price;

    typedef struct {
        logic [TAG_WIDTH-1:0] tag;
        t_price               open;
        t_price               high;
        t_price               low;
        t_price               close;
    } t_bar;

    typedef struct {
        logic [TAG_WIDTH-1:0] tag;
        t_price               open;
        t_price               close;
        t_price               high;
        t_price               low;
    } t_window;

    // Tracks the bar history and the window length, and queues the summaries the
    // block owes us in arrival order.
    class t_ohlc_scoreboard;
        logic [TAG_WIDTH-1:0] tag_hist[DEPTH];
        t_price               close_hist[DEPTH];
        t_price               high_hist[DEPTH];
        t_price               low_hist[DEPTH];
        int                   head;
        int                   filled;
        logic [LEN_WIDTH-1:0] win_len;
        t_window              expected_windows[$];
        int                   errors;

        function new();
            head    = 0;
            filled  = 0;
            win_len = LEN_RESET;
            errors  = 0;
        endfunction

        function void set_length(logic [LEN_WIDTH-1:0] v);
            win_len = v;
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction

        // Zero acts as one, anything past the ring depth saturates.
        function int span();
            if (win_len == 0) begin
                return 1;
            end
            if (win_len > DEPTH) begin
                return DEPTH;
            end
            return int'(win_len);
        endfunction

        function void note_bar(t_bar b);
            t_window w;
            int      len;
            int      oldest;
            int      k;
            int      i;
            tag_hist[head]   = b.tag;
            close_hist[head] = b.close;
            high_hist[head]  = b.high;
            low_hist[head]   = b.low;
            head = (head + 1) % DEPTH;
            if (filled < DEPTH) begin
                filled++;
            end
            len = span();
            if (filled < len) begin
                return;
            end
            oldest  = (head + DEPTH - len) % DEPTH;
            w.tag   = tag_hist[oldest];
            w.close = close_hist[oldest];
            w.open  = b.open;
            w.high  = high_hist[oldest];
            w.low   = low_hist[oldest];
            for (i = 1; i < len; i++) begin
                k = (oldest + i) % DEPTH;
                if (high_hist[k] > w.high) begin
                    w.high = high_hist[k];
                end
                if (low_hist[k] < w.low) begin
                    w.low = low_hist[k];
                end
            end
            expected_windows.push_back(w);
        endfunction

        function void compare_field(string name, logic [PW-1:0] want, logic [PW-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_window got);
            t_window want;
            if (expected_windows.size() == 0) begin
                $error("result with nothing outstanding: window_tag %h", got.tag);
                errors++;
                return;
            end
            want = expected_windows.pop_front();
            compare_field("window_tag", want.tag, got.tag);
            compare_field("window_open", want.open, got.open);
            compare_field("window_close", want.close, got.close);
            compare_field("window_high", want.high, got.high);
            compare_field("window_low", want.low, got.low);
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [LEN_WIDTH-1:0] i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata, low bit up: bar_tag, open_price, high_price, low_price, close_price
    logic [BUS_W-1:0]     s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata, low bit up: window_tag, window_open, window_close, window_high, window_low
    logic [BUS_W-1:0]     m_axis_tdata;

    t_ohlc_scoreboard sb = new();

    int send_idle_pct = 0;   // chance per cycle that the bar source holds off
    int stall_pct     = 0;   // chance per cycle that the result sink stalls
    int cycle_count   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rolling_window_ohlc #(
        .WINDOW_MAX  (DEPTH),
        .PRICE_WIDTH (PW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rolling_window_ohlc test failed");
            $finish;
        end
    end

    // Result sink: check every accepted transaction, then pick next cycle's tready.
    always @(posedge i_clk) begin : result_sink
        t_window got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.tag   = m_axis_tdata[0 +: TAG_WIDTH];
                got.open  = m_axis_tdata[TAG_WIDTH +: PW];
                got.close = m_axis_tdata[TAG_WIDTH + PW +: PW];
                got.high  = m_axis_tdata[TAG_WIDTH + 2 * PW +: PW];
                got.low   = m_axis_tdata[TAG_WIDTH + 3 * PW +: PW];
                sb.check_result(got);
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Mostly corner values and tight clusters so max/min ties show up often.
    function automatic t_price rand_price();
        case ($urandom_range(9))
            0: return PRICE_MIN;
            1: return PRICE_MAX;
            2: return '0;
            3: return -1;
            4, 5: return t_price'($signed($urandom_range(16)) - 8);
            default: return t_price'($urandom());
        endcase
    endfunction

    // Present one bar, with random hold-off first; returns once the transaction is taken.
    // tvalid is left high so back-to-back bars never toggle it within one step.
    task automatic send_bar(input t_bar b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.close, b.low, b.high, b.open, b.tag};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_bar(b);
    endtask

    // Stop sending, wait out every owed result, then let any silent sweep finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Length changes only with the block idle; held bars survive the change.
    task automatic configure_length(input logic [LEN_WIDTH-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_length(v);
    endtask

    initial begin : stimulus
        t_bar                 b;
        logic [LEN_WIDTH-1:0] len;
        int                   p;
        int                   n;

        send_idle_pct = 32;
        stall_pct     = 45;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 25 bars at the reset length of 25, so exactly the last one
        // produces a summary covering all of them.
        for (n = 0; n < 25; n++) begin
            b.tag   = n;
            b.open  = t_price'(n << 16);
            b.high  = t_price'((n + 1) << 16);
            b.low   = -t_price'(n << 16);
            b.close = t_price'(n << 15);
            case (n)
                0: begin
                    // oldest bar: all-ones tag, most negative close
                    b = '{32'hFFFF_FFFF, PRICE_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN};
                end
                7: begin
                    // carries the window extremes
                    b = '{32'h0000_0000, PRICE_MIN, PRICE_MAX, PRICE_MIN, PRICE_MAX};
                end
                12: begin
                    b = '{32'h5555_5555, '0, '0, '0, '0};
                end
                13, 14: begin
                    // equal high and low
                    b.high = 32'sh0001_8000;
                    b.low  = 32'sh0001_8000;
                end
                24: begin
                    b.tag  = 32'hAAAA_AAAA;
                    b.open = PRICE_MIN;
                end
                default: ;
            endcase
            send_bar(b);
        end

        // Random phases, each under its own window length; extremes come early.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 4) begin
                send_idle_pct = 45;
                stall_pct     = 32;
            end else if (p == 8) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            case (p)
                0: len = 7'd0;       // behaves as one
                1: len = 7'd127;     // saturates to the ring depth
                2: len = 7'd1;
                3: len = 7'd64;
                4: len = 7'd2;
                5: len = 7'd65;
                6: len = 7'd63;
                7: len = LEN_RESET;
                default: len = LEN_WIDTH'($urandom_range(127));
            endcase
            configure_length(len);
            for (n = 0; n < BARS_PER_PHASE; n++) begin
                case ($urandom_range(15))
                    0: b.tag = '0;
                    1: b.tag = '1;
                    default: b.tag = $urandom();
                endcase
                b.open  = rand_price();
                b.high  = rand_price();
                b.low   = rand_price();
                b.close = rand_price();
                send_bar(b);
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("rolling_window_ohlc test passed");
        end else begin
            $display("rolling_window_ohlc test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rwo_pkg.sv
rtl/core/rwo_cell.sv
rtl/core/rolling_window_ohlc.sv
tb/sv/rolling_window_ohlc_tb.sv
